// ----- design/bce_pkg.sv -----
// ----------------------------------------------------------------------------
// B-spline curve evaluator package
// Shared widths, command and register codes, defaults and sequencer states.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int DEF_MAX_ORDER = 8;
    localparam int DEF_MAX_KNOTS = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int VAL_W      = 32;
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int ORDER_W    = 4;
    localparam int COUNT_W    = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [ORDER_W-1:0] ORDER_RST = 4'd2;
    localparam logic [COUNT_W-1:0] COUNT_RST = 7'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_KNOT = 2'd0,
        CMD_CTRL = 2'd1,
        CMD_EVAL = 2'd2
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ORDER = 1'b0,
        REG_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_LD_RD,
        ST_LD_WR,
        ST_STEP_RD,
        ST_STEP_SET,
        ST_DIV,
        ST_ALPHA,
        ST_MUL,
        ST_WB,
        ST_FIN_RD,
        ST_FIN
    } state_t;

endpackage

// ----- design/bce_if.sv -----
// ----------------------------------------------------------------------------
// B-spline curve evaluator channels
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bce_item_if;
    import bce_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value_x;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] param_coord;

    modport source (output valid, cmd, index, value_x, value_y, param_coord, input ready);
    modport sink   (input valid, cmd, index, value_x, value_y, param_coord, output ready);
endinterface

interface bce_result_if;
    import bce_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] point_x;
    logic signed [VAL_W-1:0] point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface bce_cfg_if;
    import bce_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- design/bspline_curve_point_eval_top.sv -----
// ----------------------------------------------------------------------------
// B-spline curve point evaluator
// Holds one planar B-spline in knot and control point memories and evaluates
// it with de Boor's recursion on a small work memory, X axis then Y axis.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  item     in         cmd, index, value_x, value_y, param_coord
//  result   out        point_x, point_y (one per evaluate command)
//  cfg      in         addr (0 order, 1 knot count), data
//
// A load command writes its table entry from the idle state. An evaluate
// command, per axis, steps the knot search until the interval is found, fills
// the work memory with k control points, runs k*(k-1)/2 interpolations, each
// with a bit-serial division of DW = 33+FRAC_BITS quotient bits (skipped when
// the two knots are equal), and then finishes.
// Items are taken only while the sequencer is idle; a finished result waits
// in the output register, and the next item may be taken meanwhile.
// Reset is asynchronous, clears control state and sets the configuration to its defaults.
// ----------------------------------------------------------------------------
module bspline_curve_point_eval_top
    import bce_pkg::*;
#(
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    parameter int MAX_KNOTS = DEF_MAX_KNOTS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    bce_item_if.sink      item,
    bce_result_if.source  result,
    bce_cfg_if.sink       cfg
);

    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int WAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW  = $clog2(MAX_ORDER + 1);
    localparam int IW  = $clog2(MAX_KNOTS + 2 * MAX_ORDER + (1 << COUNT_W)) + 1;
    localparam int DW  = VAL_W + 1 + FRAC_BITS;
    localparam int DCW = $clog2(DW + 1);
    localparam int PW  = 2 * VAL_W + 1;

    localparam logic [DW-1:0]          QMAX  = DW'(1) << (VAL_W - 1);
    localparam logic signed [PW-1:0]   SMAX  = PW'(2147483647);
    localparam logic signed [PW-1:0]   SMIN  = ~SMAX;
    localparam logic signed [PW-1:0]   HALF  = PW'(1) <<< (FRAC_BITS - 1);

    // Configuration
    logic [ORDER_W-1:0] order_reg;
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RST;
            count_reg <= COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.addr)
                REG_ORDER: order_reg <= cfg.data[ORDER_W-1:0];
                REG_COUNT: count_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Sequencer state
    state_t                  state_reg, state_next;
    logic [IW-1:0]           k_reg, k_next;
    logic [IW-1:0]           n_reg, n_next;
    logic [IW-1:0]           lk_reg, lk_next;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           r_reg, r_next;
    logic                    axis_reg, axis_next;
    logic signed [VAL_W-1:0] t_reg, t_next;
    logic [VAL_W:0]          den_reg, den_next;
    logic [VAL_W:0]          rem_reg, rem_next;
    logic [DW-1:0]           dq_reg, dq_next;
    logic [DCW-1:0]          dcnt_reg, dcnt_next;
    logic                    neg_reg, neg_next;
    logic signed [VAL_W-1:0] alpha_reg, alpha_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [VAL_W-1:0] px_reg, px_next;
    logic                    res_valid_reg, res_valid_next;
    logic signed [VAL_W-1:0] res_x_reg, res_x_next;
    logic signed [VAL_W-1:0] res_y_reg, res_y_next;

    // Memories and their read registers
    logic signed [VAL_W-1:0] knot_x_mem [MAX_KNOTS];
    logic signed [VAL_W-1:0] knot_y_mem [MAX_KNOTS];
    logic signed [VAL_W-1:0] ctrl_x_mem [MAX_KNOTS];
    logic signed [VAL_W-1:0] ctrl_y_mem [MAX_KNOTS];
    logic signed [VAL_W-1:0] work_mem   [MAX_ORDER];

    logic signed [VAL_W-1:0] ka_x_reg, ka_y_reg, kb_x_reg, kb_y_reg, c_x_reg, c_y_reg;
    logic                    oob_ka_reg, oob_kb_reg, oob_c_reg;
    logic signed [VAL_W-1:0] w0_reg, w1_reg;

    logic                    ka_re, kb_re, c_re, w_re, w_we, knot_we, ctrl_we;
    logic [IW-1:0]           ka_idx, kb_idx, c_idx, wr_idx;
    logic [WAW-1:0]          w0_addr, w1_addr, w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic                    wr_ok;

    assign wr_idx = IW'(item.index);
    assign wr_ok  = wr_idx < IW'(MAX_KNOTS);

    always_ff @(posedge clk)
    begin
        if (knot_we)
        begin
            knot_x_mem[wr_idx[AW-1:0]] <= item.value_x;
            knot_y_mem[wr_idx[AW-1:0]] <= item.value_y;
        end
        if (ctrl_we)
        begin
            ctrl_x_mem[wr_idx[AW-1:0]] <= item.value_x;
            ctrl_y_mem[wr_idx[AW-1:0]] <= item.value_y;
        end
        if (ka_re)
        begin
            ka_x_reg   <= knot_x_mem[ka_idx[AW-1:0]];
            ka_y_reg   <= knot_y_mem[ka_idx[AW-1:0]];
            oob_ka_reg <= ka_idx >= IW'(MAX_KNOTS);
        end
        if (kb_re)
        begin
            kb_x_reg   <= knot_x_mem[kb_idx[AW-1:0]];
            kb_y_reg   <= knot_y_mem[kb_idx[AW-1:0]];
            oob_kb_reg <= kb_idx >= IW'(MAX_KNOTS);
        end
        if (c_re)
        begin
            c_x_reg   <= ctrl_x_mem[c_idx[AW-1:0]];
            c_y_reg   <= ctrl_y_mem[c_idx[AW-1:0]];
            oob_c_reg <= c_idx >= IW'(MAX_KNOTS);
        end
        if (w_we)
        begin
            work_mem[w_waddr] <= w_wdata;
        end
        if (w_re)
        begin
            w0_reg <= work_mem[w0_addr];
            w1_reg <= work_mem[w1_addr];
        end
    end

    // Datapath helpers; reads beyond the tables count as zero.
    logic signed [VAL_W-1:0] ka_val, kb_val, c_val;
    logic [IW-1:0]           lp_w, k_clamp, n_clamp;
    logic signed [VAL_W:0]   num_w, den_w, diff_w;
    logic [VAL_W:0]          num_mag, den_mag;
    logic [VAL_W+1:0]        trial_w;
    logic [DW-1:0]           q_sat;
    logic [VAL_W:0]          q33, a33;
    logic signed [PW-1:0]    rnd_w, sum_w;

    assign ka_val  = oob_ka_reg ? '0 : (axis_reg ? ka_y_reg : ka_x_reg);
    assign kb_val  = oob_kb_reg ? '0 : (axis_reg ? kb_y_reg : kb_x_reg);
    assign c_val   = oob_c_reg  ? '0 : (axis_reg ? c_y_reg  : c_x_reg);
    assign lp_w    = lk_reg + IW'(1) - k_reg;
    assign k_clamp = (order_reg == '0) ? IW'(1)
                   : ((IW'(order_reg) > IW'(MAX_ORDER)) ? IW'(MAX_ORDER) : IW'(order_reg));
    assign n_clamp = (IW'(count_reg) > IW'(MAX_KNOTS)) ? IW'(MAX_KNOTS) : IW'(count_reg);
    assign num_w   = (VAL_W+1)'(t_reg) - (VAL_W+1)'(ka_val);
    assign den_w   = (VAL_W+1)'(kb_val) - (VAL_W+1)'(ka_val);
    assign num_mag = num_w[VAL_W] ? (VAL_W+1)'(-num_w) : (VAL_W+1)'(num_w);
    assign den_mag = den_w[VAL_W] ? (VAL_W+1)'(-den_w) : (VAL_W+1)'(den_w);
    assign trial_w = {rem_reg, dq_reg[DW-1]};
    assign q_sat   = (dq_reg > QMAX) ? QMAX : dq_reg;
    assign q33     = q_sat[VAL_W:0];
    assign a33     = neg_reg ? (VAL_W+1)'(-q33) : q33;
    assign diff_w  = (VAL_W+1)'(w1_reg) - (VAL_W+1)'(w0_reg);
    assign rnd_w   = (prod_reg + HALF) >>> FRAC_BITS;
    assign sum_w   = PW'(w0_reg) + rnd_w;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        lk_next        = lk_reg;
        i_next         = i_reg;
        r_next         = r_reg;
        axis_next      = axis_reg;
        t_next         = t_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        dcnt_next      = dcnt_reg;
        neg_next       = neg_reg;
        alpha_next     = alpha_reg;
        prod_next      = prod_reg;
        px_next        = px_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_valid_next = res_valid_reg && !result.ready;
        ka_re          = 1'b0;
        kb_re          = 1'b0;
        c_re           = 1'b0;
        w_re           = 1'b0;
        w_we           = 1'b0;
        knot_we        = 1'b0;
        ctrl_we        = 1'b0;
        ka_idx         = lp_w + IW'(i_reg);
        kb_idx         = lk_reg + IW'(1) + IW'(i_reg) - IW'(r_reg);
        c_idx          = lp_w + IW'(i_reg);
        w0_addr        = WAW'(i_reg - CW'(1));
        w1_addr        = i_reg[WAW-1:0];
        w_waddr        = i_reg[WAW-1:0];
        w_wdata        = c_val;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    unique case (item.cmd)
                        CMD_KNOT: knot_we = wr_ok;
                        CMD_CTRL: ctrl_we = wr_ok;
                        CMD_EVAL:
                        begin
                            t_next     = item.param_coord;
                            k_next     = k_clamp;
                            n_next     = n_clamp;
                            lk_next    = k_clamp - IW'(1);
                            axis_next  = 1'b0;
                            state_next = ST_SRCH_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                if (lk_reg + k_reg + IW'(1) < n_reg)
                begin
                    ka_re      = 1'b1;
                    ka_idx     = lk_reg + IW'(1);
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_LD_RD;
                end
            end
            ST_SRCH_CMP:
            begin
                if (ka_val < t_reg)
                begin
                    lk_next    = lk_reg + IW'(1);
                    state_next = ST_SRCH_RD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_LD_RD;
                end
            end
            ST_LD_RD:
            begin
                c_re       = 1'b1;
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                w_we = 1'b1;
                if (IW'(i_reg) == k_reg - IW'(1))
                begin
                    r_next     = CW'(1);
                    state_next = ST_STEP_RD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_LD_RD;
                end
            end
            ST_STEP_RD:
            begin
                if (IW'(r_reg) >= k_reg)
                begin
                    state_next = ST_FIN_RD;
                end
                else
                begin
                    ka_re      = 1'b1;
                    kb_re      = 1'b1;
                    w_re       = 1'b1;
                    state_next = ST_STEP_SET;
                end
            end
            ST_STEP_SET:
            begin
                if (ka_val == kb_val)
                begin
                    alpha_next = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    neg_next   = num_w[VAL_W] != den_w[VAL_W];
                    den_next   = den_mag;
                    rem_next   = '0;
                    dq_next    = {num_mag, {FRAC_BITS{1'b0}}};
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle, restoring form.
                if (trial_w >= {1'b0, den_reg})
                begin
                    rem_next = (VAL_W+1)'(trial_w - {1'b0, den_reg});
                    dq_next  = {dq_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial_w[VAL_W:0];
                    dq_next  = {dq_reg[DW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(DW - 1))
                begin
                    state_next = ST_ALPHA;
                end
            end
            ST_ALPHA:
            begin
                if (!neg_reg && q_sat == QMAX)
                begin
                    alpha_next = VAL_W'(SMAX);
                end
                else
                begin
                    alpha_next = a33[VAL_W-1:0];
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PW'(alpha_reg) * PW'(diff_w);
                state_next = ST_WB;
            end
            ST_WB:
            begin
                w_we = 1'b1;
                if (sum_w > SMAX)
                begin
                    w_wdata = VAL_W'(SMAX);
                end
                else if (sum_w < SMIN)
                begin
                    w_wdata = VAL_W'(SMIN);
                end
                else
                begin
                    w_wdata = sum_w[VAL_W-1:0];
                end
                if (i_reg == r_reg)
                begin
                    r_next = r_reg + CW'(1);
                    i_next = CW'(k_reg - IW'(1));
                end
                else
                begin
                    i_next = i_reg - CW'(1);
                end
                state_next = ST_STEP_RD;
            end
            ST_FIN_RD:
            begin
                w_re       = 1'b1;
                w0_addr    = WAW'(k_reg - IW'(1));
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!axis_reg)
                begin
                    px_next    = w0_reg;
                    axis_next  = 1'b1;
                    lk_next    = k_reg - IW'(1);
                    state_next = ST_SRCH_RD;
                end
                else if (!res_valid_reg || result.ready)
                begin
                    res_x_next     = px_reg;
                    res_y_next     = w0_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            k_reg         <= '0;
            n_reg         <= '0;
            lk_reg        <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
            axis_reg      <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            lk_reg        <= lk_next;
            i_reg         <= i_next;
            r_reg         <= r_next;
            axis_reg      <= axis_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        neg_reg   <= neg_next;
        alpha_reg <= alpha_next;
        prod_reg  <= prod_next;
        px_reg    <= px_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
    end

    assign item.ready     = (state_reg == ST_IDLE);
    assign result.valid   = res_valid_reg;
    assign result.point_x = res_x_reg;
    assign result.point_y = res_y_reg;

    // The divider never runs past its last quotient bit.
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dcnt_reg < DCW'(DW))
        else $error("divider step count out of range");

    // Write-back stays inside the triangle of the recursion.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WB |-> (r_reg <= i_reg && IW'(i_reg) < k_reg))
        else $error("interpolation index outside the triangle");

    // The knot interval never falls below order minus one.
    a_lk_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP_RD |-> lk_reg + IW'(1) >= k_reg)
        else $error("knot interval below its lower bound");

    // A result appears only at the end of the Y axis pass.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FIN && axis_reg))
        else $error("result raised outside the final state");

endmodule
